>>> sv/turtle_symbol_interpreter_unit_macros.svh
// Assertion macros for the turtle symbol interpreter.
// Used by the top level; define ASSERT_OFF to compile them away.
`ifndef TURTLE_SYMBOL_INTERPRETER_UNIT_MACROS_SVH
`define TURTLE_SYMBOL_INTERPRETER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at every clock edge outside reset.
`define TSI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define TSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define TSI_ASSERT(lbl, clk, rstn, prop, msg)
`define TSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> sv/tsi_pkg.sv
// Shared types and constants of the turtle symbol interpreter.
// No dependencies; used by every module of the block.
`default_nettype none

package tsi_pkg;

  localparam int POS_W     = 32;
  localparam int CFG_W     = 16;
  localparam int RAD_W     = 15;
  localparam int CMD_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN = 1'b1;

  // Configuration reset values (Q1.14)
  localparam logic [CFG_W-1:0] COS_RESET = 16'h4000;
  localparam logic [CFG_W-1:0] SIN_RESET = 16'h0000;

  // Symbol codes
  localparam logic [CMD_W-1:0] CMD_MOVE_X = 8'h58;
  localparam logic [CMD_W-1:0] CMD_MOVE_Y = 8'h59;
  localparam logic [CMD_W-1:0] CMD_MOVE_Z = 8'h5A;
  localparam logic [CMD_W-1:0] CMD_YAW_P  = 8'h2B;
  localparam logic [CMD_W-1:0] CMD_YAW_N  = 8'h2D;
  localparam logic [CMD_W-1:0] CMD_PIT_P  = 8'h26;
  localparam logic [CMD_W-1:0] CMD_PIT_N  = 8'h5E;
  localparam logic [CMD_W-1:0] CMD_ROL_P  = 8'h5C;
  localparam logic [CMD_W-1:0] CMD_ROL_N  = 8'h2F;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 8'h5B;
  localparam logic [CMD_W-1:0] CMD_POP    = 8'h5D;

  typedef enum logic [1:0] {
    ST_SPHERE    = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_vec_t;

endpackage

`default_nettype wire

>>> sv/tsi_stack_mem.sv
// Position stack memory: one write port, one read port, registered read data.
// Depends on tsi_pkg for the position vector type.
`default_nettype none

module tsi_stack_mem
  import tsi_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire pos_vec_t          wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      pos_vec_t          rdata_o
);

  pos_vec_t mem_q [DEPTH];
  pos_vec_t rdata_q;

  // Write the pushed position
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read the popped position; hold it until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/tsi_rotate.sv
// Heading rotator: turns a pair of heading components by the configured angle.
// Depends on tsi_pkg for the configuration width.
`default_nettype none

module tsi_rotate
  import tsi_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire logic signed [CFG_W-1:0]       cos_i,
  input  wire logic signed [CFG_W-1:0]       sin_i,
  input  wire logic                          dir_pos_i,
  input  wire logic signed [FRAC_BITS+1:0]   a_i,
  input  wire logic signed [FRAC_BITS+1:0]   b_i,
  output      logic signed [FRAC_BITS+1:0]   a_o,
  output      logic signed [FRAC_BITS+1:0]   b_o
);

  localparam int HW = FRAC_BITS + 2;
  localparam int PW = CFG_W + HW;
  localparam int SW = PW + 2;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0] c_ext, s_ext, a_ext, b_ext;
  logic signed [PW-1:0] ca, cb, sa, sb;
  logic signed [SW-1:0] na, nb, ra, rb;

  assign c_ext = $signed({{(PW-CFG_W){cos_i[CFG_W-1]}}, cos_i});
  assign s_ext = $signed({{(PW-CFG_W){sin_i[CFG_W-1]}}, sin_i});
  assign a_ext = $signed({{(PW-HW){a_i[HW-1]}}, a_i});
  assign b_ext = $signed({{(PW-HW){b_i[HW-1]}}, b_i});

  // Four products of the rotation matrix
  assign ca = c_ext * a_ext;
  assign cb = c_ext * b_ext;
  assign sa = s_ext * a_ext;
  assign sb = s_ext * b_ext;

  // Combine with the sign of the turn, then round to nearest
  always_comb begin
    if (dir_pos_i) begin
      na = SW'(ca) - SW'(sb);
      nb = SW'(sa) + SW'(cb);
    end else begin
      na = SW'(ca) + SW'(sb);
      nb = SW'(cb) - SW'(sa);
    end
    ra = (na + $signed(HALF)) >>> FRAC_BITS;
    rb = (nb + $signed(HALF)) >>> FRAC_BITS;
  end

  // Saturate back to the heading width
  always_comb begin
    if (ra[SW-1:HW-1] == '0 || ra[SW-1:HW-1] == '1) begin
      a_o = ra[HW-1:0];
    end else begin
      a_o = ra[SW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
    end
    if (rb[SW-1:HW-1] == '0 || rb[SW-1:HW-1] == '1) begin
      b_o = rb[HW-1:0];
    end else begin
      b_o = rb[SW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

>>> sv/tsi_advance.sv
// Move unit: adds radius times heading to the position, one lane per axis.
// Depends on tsi_pkg for widths and the position vector type.
`default_nettype none

module tsi_advance
  import tsi_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire pos_vec_t                     pos_i,
  input  wire logic signed [FRAC_BITS+1:0]  head_x_i,
  input  wire logic signed [FRAC_BITS+1:0]  head_y_i,
  input  wire logic signed [FRAC_BITS+1:0]  head_z_i,
  input  wire logic [RAD_W-1:0]             radius_i,
  output      pos_vec_t                     pos_o
);

  localparam int HW   = FRAC_BITS + 2;
  localparam int MW   = RAD_W + 1 + HW;
  localparam int SUMW = (MW + 2 > POS_W + 1) ? MW + 2 : POS_W + 1;
  localparam logic [SUMW-1:0] HALF = SUMW'(1) << (FRAC_BITS - 1);

  logic signed [HW-1:0]    head [3];
  logic signed [POS_W-1:0] pos_in [3];
  logic signed [POS_W-1:0] pos_out [3];
  logic signed [MW-1:0]    rad_ext;

  assign head[0]   = head_x_i;
  assign head[1]   = head_y_i;
  assign head[2]   = head_z_i;
  assign pos_in[0] = pos_i.x;
  assign pos_in[1] = pos_i.y;
  assign pos_in[2] = pos_i.z;
  assign rad_ext   = $signed({{(MW-RAD_W){1'b0}}, radius_i});

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [MW-1:0]   head_ext;
    logic signed [MW-1:0]   prod;
    logic signed [SUMW-1:0] delta;
    logic signed [SUMW-1:0] sum;

    assign head_ext = $signed({{(MW-HW){head[g][HW-1]}}, head[g]});
    assign prod     = rad_ext * head_ext;

    // Round the step, add it and saturate to the position width
    assign delta = ($signed({{(SUMW-MW){prod[MW-1]}}, prod}) + $signed(HALF)) >>> FRAC_BITS;
    assign sum   = $signed({{(SUMW-POS_W){pos_in[g][POS_W-1]}}, pos_in[g]}) + delta;

    always_comb begin
      if (sum[SUMW-1:POS_W-1] == '0 || sum[SUMW-1:POS_W-1] == '1) begin
        pos_out[g] = sum[POS_W-1:0];
      end else begin
        pos_out[g] = sum[SUMW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  always_comb begin
    pos_o.x = pos_out[0];
    pos_o.y = pos_out[1];
    pos_o.z = pos_out[2];
  end

endmodule

`default_nettype wire

>>> sv/turtle_symbol_interpreter_unit.sv
// Turtle symbol interpreter: one symbol per beat, any result in the cycle after acceptance.
// Throughput is one symbol per cycle unless a pending result is not taken; a pop reads the
// stack memory and its data is forwarded from the memory read register to the next accepted symbol.
// A result is held in the result register, which is loaded when its symbol is accepted.
// Reset: heading (one, 0, 0), position 0, stack empty, cos one, sin 0, no result
// pending; the stack memory is not cleared and needs no clearing pass.
`default_nettype none
`include "turtle_symbol_interpreter_unit_macros.svh"

module turtle_symbol_interpreter_unit
  import tsi_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 14
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  // symbol channel
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic [CMD_W-1:0]        cmd_i,
  input  wire logic [RAD_W-1:0]        step_radius_i,
  input  wire logic                    start_string_i,
  // result channel
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic signed [POS_W-1:0] pos_x_o,
  output      logic signed [POS_W-1:0] pos_y_o,
  output      logic signed [POS_W-1:0] pos_z_o,
  output      logic [RAD_W-1:0]        sphere_radius_o,
  output      logic [1:0]              status_o
);

  localparam int HW     = FRAC_BITS + 2;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic signed [HW-1:0] HEAD_ONE = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic [LVL_W-1:0]     LVL_FULL = LVL_W'(STACK_DEPTH);

  typedef enum logic [1:0] {
    PAIR_XY,
    PAIR_ZX,
    PAIR_ZY
  } pair_e;

  // Configuration and turtle state
  logic signed [CFG_W-1:0] cos_q, sin_q;
  logic signed [HW-1:0]    head_x_q, head_y_q, head_z_q;
  pos_vec_t                pos_q;
  logic                    pos_from_mem_q;
  logic [LVL_W-1:0]        lvl_q;

  // Result register
  logic                    out_valid_q;
  pos_vec_t                out_pos_q;
  logic [RAD_W-1:0]        out_rad_q;
  status_e                 out_status_q;

  logic                    in_fire;
  logic signed [HW-1:0]    cur_hx, cur_hy, cur_hz;
  pos_vec_t                mem_rdata, cur_pos, adv_pos, wr_pos, res_pos;
  logic [LVL_W-1:0]        cur_lvl, lvl_dec, lvl_d;
  logic                    is_move, is_turn, is_push, is_pop, is_unknown, turn_pos;
  pair_e                   pair;
  logic                    push_ok, pop_ok, has_res;
  status_e                 res_status;
  logic signed [HW-1:0]    rot_a, rot_b, rot_a_new, rot_b_new;
  logic signed [HW-1:0]    hx_d, hy_d, hz_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= COS_RESET;
      sin_q <= SIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COS: cos_q <= cfg_data_i;
        CFG_SIN: sin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective state for this beat: home on start, popped position forwarded
  always_comb begin
    if (start_string_i) begin
      cur_hx  = HEAD_ONE;
      cur_hy  = '0;
      cur_hz  = '0;
      cur_pos = '0;
      cur_lvl = '0;
    end else begin
      cur_hx  = head_x_q;
      cur_hy  = head_y_q;
      cur_hz  = head_z_q;
      cur_pos = pos_from_mem_q ? mem_rdata : pos_q;
      cur_lvl = lvl_q;
    end
  end

  assign lvl_dec = cur_lvl - LVL_W'(1);

  // Decode the symbol
  always_comb begin
    is_move    = 1'b0;
    is_turn    = 1'b0;
    is_push    = 1'b0;
    is_pop     = 1'b0;
    is_unknown = 1'b0;
    turn_pos   = 1'b1;
    pair       = PAIR_XY;
    unique case (cmd_i)
      CMD_MOVE_X, CMD_MOVE_Y, CMD_MOVE_Z: is_move = 1'b1;
      CMD_YAW_P: begin is_turn = 1'b1; pair = PAIR_XY; turn_pos = 1'b1; end
      CMD_YAW_N: begin is_turn = 1'b1; pair = PAIR_XY; turn_pos = 1'b0; end
      CMD_PIT_P: begin is_turn = 1'b1; pair = PAIR_ZX; turn_pos = 1'b1; end
      CMD_PIT_N: begin is_turn = 1'b1; pair = PAIR_ZX; turn_pos = 1'b0; end
      CMD_ROL_P: begin is_turn = 1'b1; pair = PAIR_ZY; turn_pos = 1'b1; end
      CMD_ROL_N: begin is_turn = 1'b1; pair = PAIR_ZY; turn_pos = 1'b0; end
      CMD_PUSH:  is_push = 1'b1;
      CMD_POP:   is_pop = 1'b1;
      default:   is_unknown = 1'b1;
    endcase
  end

  assign push_ok = is_push && (cur_lvl != LVL_FULL);
  assign pop_ok  = is_pop && (cur_lvl != '0);

  // Pick the heading pair to turn and write the turned pair back
  always_comb begin
    unique case (pair)
      PAIR_XY: begin rot_a = cur_hx; rot_b = cur_hy; end
      PAIR_ZX: begin rot_a = cur_hz; rot_b = cur_hx; end
      PAIR_ZY: begin rot_a = cur_hz; rot_b = cur_hy; end
      default: begin rot_a = cur_hx; rot_b = cur_hy; end
    endcase
    hx_d = cur_hx;
    hy_d = cur_hy;
    hz_d = cur_hz;
    if (is_turn) begin
      unique case (pair)
        PAIR_XY: begin hx_d = rot_a_new; hy_d = rot_b_new; end
        PAIR_ZX: begin hz_d = rot_a_new; hx_d = rot_b_new; end
        PAIR_ZY: begin hz_d = rot_a_new; hy_d = rot_b_new; end
        default: ;
      endcase
    end
  end

  tsi_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .cos_i     (cos_q),
    .sin_i     (sin_q),
    .dir_pos_i (turn_pos),
    .a_i       (rot_a),
    .b_i       (rot_b),
    .a_o       (rot_a_new),
    .b_o       (rot_b_new)
  );

  tsi_advance #(
    .FRAC_BITS (FRAC_BITS)
  ) u_advance (
    .pos_i    (cur_pos),
    .head_x_i (cur_hx),
    .head_y_i (cur_hy),
    .head_z_i (cur_hz),
    .radius_i (step_radius_i),
    .pos_o    (adv_pos)
  );

  tsi_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire && push_ok),
    .waddr_i (cur_lvl[ADDR_W-1:0]),
    .wdata_i (cur_pos),
    .re_i    (in_fire && pop_ok),
    .raddr_i (lvl_dec[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // Next position, level and result of this beat
  always_comb begin
    wr_pos     = is_move ? adv_pos : cur_pos;
    res_pos    = wr_pos;
    has_res    = is_move || is_unknown || (is_push && !push_ok) || (is_pop && !pop_ok);
    res_status = ST_SPHERE;
    if (is_unknown) begin
      res_status = ST_UNKNOWN;
    end else if (is_pop) begin
      res_status = ST_POP_EMPTY;
    end else if (is_push) begin
      res_status = ST_PUSH_FULL;
    end
    if (push_ok) begin
      lvl_d = cur_lvl + LVL_W'(1);
    end else if (pop_ok) begin
      lvl_d = lvl_dec;
    end else begin
      lvl_d = cur_lvl;
    end
  end

  // Advance the turtle state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_x_q       <= HEAD_ONE;
      head_y_q       <= '0;
      head_z_q       <= '0;
      pos_q          <= '0;
      pos_from_mem_q <= 1'b0;
      lvl_q          <= '0;
    end else if (in_fire) begin
      head_x_q       <= hx_d;
      head_y_q       <= hy_d;
      head_z_q       <= hz_d;
      pos_q          <= wr_pos;
      pos_from_mem_q <= pop_ok;
      lvl_q          <= lvl_d;
    end
  end

  // Result register: load on an accepted beat, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= has_res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && has_res) begin
      out_pos_q    <= res_pos;
      out_rad_q    <= is_move ? step_radius_i : '0;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = out_pos_q.x;
  assign pos_y_o         = out_pos_q.y;
  assign pos_z_o         = out_pos_q.z;
  assign sphere_radius_o = out_rad_q;
  assign status_o        = out_status_q;

  `TSI_ASSERT(a_lvl_bound, clk_i, rst_ni, lvl_q <= LVL_FULL, "stack level beyond depth")
  `TSI_ASSERT_NEXT(a_push_full, clk_i, rst_ni, in_fire && !start_string_i && (cmd_i == CMD_PUSH) && (lvl_q == LVL_FULL), out_valid_q && (out_status_q == ST_PUSH_FULL), "push on full stack not reported")
  `TSI_ASSERT_NEXT(a_pop_start, clk_i, rst_ni, in_fire && start_string_i && (cmd_i == CMD_POP), out_valid_q && (out_status_q == ST_POP_EMPTY), "pop after start not reported as empty")
  `TSI_ASSERT_NEXT(a_turn_silent, clk_i, rst_ni, in_fire && is_turn, !out_valid_q, "turn produced a result")

endmodule

`default_nettype wire
